// ----- src/lhist_pkg.sv -----
package lhist_pkg;

    localparam int BUCKETS_DEF = 64;
    localparam int DIV_W = 96;
    localparam logic [19:0] PPM_FULL = 20'd1000000;
    localparam logic [62:0] MAX63 = {63{1'b1}};

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_REC_RD,
        ST_REC_WR,
        ST_MUL,
        ST_DM_GO,
        ST_DM_WAIT,
        ST_WALK_RD,
        ST_WALK_ACC,
        ST_WALK_CMP,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic cap_in;
        logic rec_rd;
        logic rec_wr;
        logic mul_step;
        logic div_go;
        logic mean_load;
        logic walk_rd;
        logic walk_acc;
        logic walk_cmp;
        logic out_load;
        logic clear;
    } cmd_t;

    typedef struct packed {
        logic mul_last;
        logic div_done;
        logic walk_end;
        logic out_free;
        logic cnt_zero;
    } sts_t;

endpackage

// ----- src/log2_latency_histogram_unit.sv -----
// Latency histogram with log2 buckets. The s_ channel carries one word per
// item: s_kind 0 records s_sample_ns, s_kind 1 asks for statistics. A record
// is counted in the bucket given by the bit width of the sample, and the count,
// sum, minimum and maximum are updated. A query returns one m_ word with count,
// minimum, maximum, floor mean and the percentile given by s_probability_ppm.
// For a record, s_ready is low after acceptance while the bucket memory does
// its read-modify-write. A query holds s_ready low after acceptance through the
// serial rank multiply, the radix-2 mean divider, a read, accumulate and compare
// step for each bucket walked (1 to 64 buckets) and the load of the result,
// which is valid as s_ready returns. The result sits in an output register;
// when the receiver stalls, a finished result waits there and records continue,
// but the next query holds s_ready low until it can load its result. Reset
// clears all statistics at once through per-bucket valid bits.
// A query with s_clear_after set empties the store as its result is loaded.
module log2_latency_histogram_unit #(
    parameter int BUCKETS = lhist_pkg::BUCKETS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_kind,
    input  logic [63:0] s_sample_ns,
    input  logic [19:0] s_probability_ppm,
    input  logic        s_clear_after,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_total_count,
    output logic [62:0] m_min_ns,
    output logic [62:0] m_max_ns,
    output logic [62:0] m_mean_ns,
    output logic [62:0] m_percentile_ns
);
    import lhist_pkg::*;

    cmd_t   cmd;
    sts_t   sts;
    state_t state;

    lhist_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_kind        (s_kind),
        .s_clear_after (s_clear_after),
        .s_ready       (s_ready),
        .sts           (sts),
        .cmd           (cmd),
        .state         (state)
    );

    lhist_dp #(.BUCKETS(BUCKETS)) u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .sts               (sts),
        .s_sample_ns       (s_sample_ns),
        .s_probability_ppm (s_probability_ppm),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_total_count     (m_total_count),
        .m_min_ns          (m_min_ns),
        .m_max_ns          (m_max_ns),
        .m_mean_ns         (m_mean_ns),
        .m_percentile_ns   (m_percentile_ns)
    );

    a_clear_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clear |=> sts.cnt_zero)
        else $error("statistics not emptied by clear");

    a_empty_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_total_count == 64'd0) |->
        (m_min_ns == 63'd0 && m_max_ns == 63'd0 && m_percentile_ns == 63'd0))
        else $error("empty result carries nonzero fields");

    a_min_le_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_min_ns <= m_max_ns)
        else $error("result minimum above maximum");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state == ST_OUT && !sts.out_free) |=> $stable(m_total_count))
        else $error("result overwritten while stalled");
endmodule

// ----- src/lhist_ram.sv -----
module lhist_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// ----- src/lhist_div.sv -----
module lhist_div (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [lhist_pkg::DIV_W-1:0] dividend,
    input  logic [63:0]               divisor,
    output logic                      done,
    output logic [lhist_pkg::DIV_W-1:0] quot
);
    import lhist_pkg::*;

    logic [DIV_W-1:0] dvd_reg, dvd_next;
    logic [63:0]      rem_reg, rem_next;
    logic [63:0]      dsr_reg;
    logic [6:0]       cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [64:0]      shifted;
    logic [64:0]      diff;

    always_comb begin
        shifted   = {rem_reg, dvd_reg[DIV_W-1]};
        diff      = shifted - {1'b0, dsr_reg};
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            dvd_next  = dividend;
            rem_next  = '0;
            cnt_next  = 7'(DIV_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (shifted >= {1'b0, dsr_reg}) begin
                rem_next = diff[63:0];
                dvd_next = {dvd_reg[DIV_W-2:0], 1'b1};
            end else begin
                rem_next = shifted[63:0];
                dvd_next = {dvd_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        if (start) begin
            dsr_reg <= divisor;
        end
    end

    assign done   = done_reg;
    assign quot   = dvd_reg;
endmodule

// ----- src/lhist_dp.sv -----
module lhist_dp #(
    parameter int BUCKETS = lhist_pkg::BUCKETS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  lhist_pkg::cmd_t   cmd,
    output lhist_pkg::sts_t   sts,
    input  logic [63:0]       s_sample_ns,
    input  logic [19:0]       s_probability_ppm,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [63:0]       m_total_count,
    output logic [62:0]       m_min_ns,
    output logic [62:0]       m_max_ns,
    output logic [62:0]       m_mean_ns,
    output logic [62:0]       m_percentile_ns
);
    import lhist_pkg::*;

    localparam int BW = $clog2(BUCKETS);
    localparam logic [BW-1:0] LAST = BW'(BUCKETS - 1);

    logic [62:0]      v_reg;
    logic [63:0]      cnt_reg;
    logic [95:0]      sum_reg;
    logic [62:0]      min_reg, max_reg;
    logic [BUCKETS-1:0] valid_reg;
    logic             rd_valid_reg;
    logic [83:0]      prod_reg, mcand_reg;
    logic [19:0]      mplier_reg;
    logic [4:0]       mul_cnt_reg;
    logic [62:0]      mean_reg, pct_reg;
    logic [BW-1:0]    walk_reg;
    logic [63:0]      cum_reg;
    logic             m_valid_reg;
    logic [63:0]      o_cnt_reg;
    logic [62:0]      o_min_reg, o_max_reg, o_mean_reg, o_pct_reg;

    logic [5:0]       width_v;
    logic [BW-1:0]    bidx;
    logic [BW-1:0]    raddr;
    logic [63:0]      rdata, bval, inc_val;
    logic [64:0]      inc_sum, cum_sum;
    logic [63:0]      cum_next;
    logic [83:0]      cum_wide, cum_scaled;
    logic [96:0]      sum_add;
    logic [DIV_W-1:0] quot;
    logic             div_done;
    logic             hit;
    logic [5:0]       walk6;

    always_comb begin
        width_v = '0;
        for (int i = 0; i < 63; i++) begin
            if (v_reg[i]) begin
                width_v = 6'(i + 1);
            end
        end
        if (7'(width_v) > 7'(BUCKETS - 1)) begin
            bidx = LAST;
        end else begin
            bidx = width_v[BW-1:0];
        end
    end

    assign raddr   = cmd.walk_rd ? walk_reg : bidx;
    assign bval    = rd_valid_reg ? rdata : 64'd0;
    assign inc_sum = {1'b0, bval} + 65'd1;
    assign inc_val = inc_sum[64] ? {64{1'b1}} : inc_sum[63:0];
    assign cum_sum = {1'b0, cum_reg} + {1'b0, bval};
    assign cum_next = cum_sum[64] ? {64{1'b1}} : cum_sum[63:0];
    assign sum_add = {1'b0, sum_reg} + {34'd0, v_reg};
    assign walk6   = 6'(walk_reg);

    // The running count reaches the rounded-up rank exactly when one million
    // times the count reaches ppm times the sample count.
    assign cum_wide   = {20'd0, cum_reg};
    assign cum_scaled = (cum_wide << 20) - (cum_wide << 16) + (cum_wide << 14)
                      + (cum_wide << 9) + (cum_wide << 6);
    assign hit        = (cum_reg != '0) && (cum_scaled >= prod_reg);

    lhist_ram #(.WIDTH(64), .DEPTH(BUCKETS)) u_ram (
        .aclk  (aclk),
        .we    (cmd.rec_wr),
        .waddr (bidx),
        .wdata (inc_val),
        .raddr (raddr),
        .rdata (rdata)
    );

    lhist_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_go),
        .dividend (sum_reg),
        .divisor  (cnt_reg),
        .done     (div_done),
        .quot     (quot)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            sum_reg     <= '0;
            min_reg     <= '0;
            max_reg     <= '0;
            valid_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.rec_rd) begin
                if (cnt_reg == '0) begin
                    min_reg <= v_reg;
                    max_reg <= v_reg;
                end else begin
                    if (v_reg < min_reg) min_reg <= v_reg;
                    if (v_reg > max_reg) max_reg <= v_reg;
                end
                if (cnt_reg != {64{1'b1}}) cnt_reg <= cnt_reg + 64'd1;
                sum_reg <= sum_add[96] ? {96{1'b1}} : sum_add[95:0];
            end
            if (cmd.rec_wr) begin
                valid_reg[bidx] <= 1'b1;
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cmd.clear) begin
                cnt_reg   <= '0;
                sum_reg   <= '0;
                min_reg   <= '0;
                max_reg   <= '0;
                valid_reg <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rd_valid_reg <= valid_reg[raddr];
        if (cmd.cap_in) begin
            v_reg       <= s_sample_ns[63] ? 63'd0 : s_sample_ns[62:0];
            mul_cnt_reg <= '0;
        end
        if (cmd.cap_in) begin
            prod_reg <= '0;
        end else if (cmd.mul_step) begin
            if (mplier_reg[0]) prod_reg <= prod_reg + mcand_reg;
            mplier_reg  <= mplier_reg >> 1;
            mcand_reg   <= mcand_reg << 1;
            mul_cnt_reg <= mul_cnt_reg + 5'd1;
        end
        if (cmd.cap_in) begin
            mplier_reg <= (s_probability_ppm > PPM_FULL) ? PPM_FULL : s_probability_ppm;
            mcand_reg  <= {20'd0, cnt_reg};
        end
        if (cmd.mean_load) begin
            mean_reg <= (quot[95:63] != '0) ? MAX63 : quot[62:0];
            walk_reg <= '0;
            cum_reg  <= '0;
        end
        if (cmd.walk_acc) begin
            cum_reg <= cum_next;
        end
        if (cmd.walk_cmp) begin
            if (hit) begin
                if (walk6 == 6'd0) begin
                    pct_reg <= '0;
                end else if (walk6 == 6'd63) begin
                    pct_reg <= max_reg;
                end else begin
                    pct_reg <= (63'd1 << walk6) - 63'd1;
                end
            end else if (walk_reg == LAST) begin
                pct_reg <= max_reg;
            end else begin
                walk_reg <= walk_reg + BW'(1);
            end
        end
        if (cmd.out_load) begin
            o_cnt_reg  <= cnt_reg;
            o_min_reg  <= (cnt_reg == '0) ? 63'd0 : min_reg;
            o_max_reg  <= (cnt_reg == '0) ? 63'd0 : max_reg;
            o_mean_reg <= (cnt_reg == '0) ? 63'd0 : mean_reg;
            o_pct_reg  <= (cnt_reg == '0) ? 63'd0 : pct_reg;
        end
    end

    assign sts.mul_last = (mul_cnt_reg == 5'd19);
    assign sts.div_done = div_done;
    assign sts.walk_end = hit || (walk_reg == LAST);
    assign sts.out_free = !m_valid_reg || m_ready;
    assign sts.cnt_zero = (cnt_reg == '0);

    assign m_valid         = m_valid_reg;
    assign m_total_count   = o_cnt_reg;
    assign m_min_ns        = o_min_reg;
    assign m_max_ns        = o_max_reg;
    assign m_mean_ns       = o_mean_reg;
    assign m_percentile_ns = o_pct_reg;
endmodule

// ----- src/lhist_ctrl.sv -----
module lhist_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_kind,
    input  logic              s_clear_after,
    output logic              s_ready,
    input  lhist_pkg::sts_t   sts,
    output lhist_pkg::cmd_t   cmd,
    output lhist_pkg::state_t state
);
    import lhist_pkg::*;

    state_t state_reg, state_next;
    logic   clr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            clr_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cmd.cap_in) clr_reg <= s_clear_after;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.cap_in = 1'b1;
                    state_next = s_kind ? ST_MUL : ST_REC_RD;
                end
            end
            ST_REC_RD: begin
                cmd.rec_rd = 1'b1;
                state_next = ST_REC_WR;
            end
            ST_REC_WR: begin
                cmd.rec_wr = 1'b1;
                state_next = ST_IDLE;
            end
            ST_MUL: begin
                cmd.mul_step = 1'b1;
                if (sts.mul_last) state_next = ST_DM_GO;
            end
            ST_DM_GO: begin
                cmd.div_go  = 1'b1;
                state_next  = ST_DM_WAIT;
            end
            ST_DM_WAIT: begin
                if (sts.div_done) begin
                    cmd.mean_load = 1'b1;
                    state_next    = ST_WALK_RD;
                end
            end
            ST_WALK_RD: begin
                cmd.walk_rd = 1'b1;
                state_next  = ST_WALK_ACC;
            end
            ST_WALK_ACC: begin
                cmd.walk_acc = 1'b1;
                state_next   = ST_WALK_CMP;
            end
            ST_WALK_CMP: begin
                cmd.walk_cmp = 1'b1;
                state_next   = sts.walk_end ? ST_OUT : ST_WALK_RD;
            end
            ST_OUT: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.clear    = clr_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign state = state_reg;
endmodule

// ----- tb/tb_top.sv -----
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NBKT = 64;
    localparam logic [62:0] TOP63 = {63{1'b1}};
    localparam logic [63:0] ALL64 = {64{1'b1}};
    localparam logic [19:0] PPM_MAX = 20'd1000000;
    localparam logic KIND_REC = 1'b0;
    localparam logic KIND_QRY = 1'b1;

    typedef struct packed {
        logic [63:0] cnt;
        logic [62:0] mn;
        logic [62:0] mx;
        logic [62:0] mean;
        logic [62:0] pct;
    } stats_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic        s_kind;
    logic [63:0] s_sample_ns;
    logic [19:0] s_probability_ppm;
    logic        s_clear_after;
    logic        m_valid;
    logic        m_ready;
    logic [63:0] m_total_count;
    logic [62:0] m_min_ns;
    logic [62:0] m_max_ns;
    logic [62:0] m_mean_ns;
    logic [62:0] m_percentile_ns;

    log2_latency_histogram_unit DUT (.*);

    logic [63:0] hist_bins [NBKT];
    logic [63:0] hist_cnt;
    logic [95:0] hist_sum;
    logic [62:0] hist_min;
    logic [62:0] hist_max;
    stats_t      stats_q [$];
    int          errors = 0;
    bit          gaps_on = 1;
    int          hold_rx = 0;

    initial begin
        aclk = 0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #100ms;
        $display("Some tests failed");
        $finish;
    end

    function automatic logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
        logic [64:0] s;
        s = a + b;
        return s[64] ? ALL64 : s[63:0];
    endfunction

    task automatic clear_hist();
        for (int i = 0; i < NBKT; i++) hist_bins[i] = '0;
        hist_cnt = '0;
        hist_sum = '0;
        hist_min = '0;
        hist_max = '0;
    endtask

    task automatic record_sample(logic [63:0] raw);
        logic [62:0] v;
        int b;
        logic [96:0] s;
        v = raw[63] ? '0 : raw[62:0];
        b = 0;
        for (int i = 0; i < 63; i++) if (v[i]) b = i + 1;
        if (b > NBKT - 1) b = NBKT - 1;
        hist_bins[b] = add_sat(hist_bins[b], 64'd1);
        if (hist_cnt == 0) begin
            hist_min = v;
            hist_max = v;
        end else begin
            if (v < hist_min) hist_min = v;
            if (v > hist_max) hist_max = v;
        end
        hist_cnt = add_sat(hist_cnt, 64'd1);
        s = hist_sum + v;
        hist_sum = s[96] ? {96{1'b1}} : s[95:0];
    endtask

    function automatic stats_t query_stats(logic [19:0] ppm_in);
        stats_t r;
        logic [95:0] quo;
        logic [63:0] ppm, tgt, cum;
        logic [127:0] prod;
        r = '0;
        if (hist_cnt == 0) return r;
        r.cnt = hist_cnt;
        r.mn = hist_min;
        r.mx = hist_max;
        quo = hist_sum / {32'd0, hist_cnt};
        r.mean = (quo[95:63] != 0) ? TOP63 : quo[62:0];
        ppm = (ppm_in > PPM_MAX) ? 64'(PPM_MAX) : 64'(ppm_in);
        prod = hist_cnt * ppm;
        tgt = 64'((prod + 128'd999999) / 128'd1000000);
        if (tgt == 0) tgt = 1;
        cum = 0;
        r.pct = hist_max;
        for (int b = 0; b < NBKT; b++) begin
            cum = add_sat(cum, hist_bins[b]);
            if (cum >= tgt) begin
                if (b == 0) r.pct = '0;
                else if (b >= 63) r.pct = hist_max;
                else r.pct = (63'd1 << b) - 63'd1;
                break;
            end
        end
        return r;
    endfunction

    task automatic send_word(logic kind, logic [63:0] smp, logic [19:0] ppm, logic clr);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 0;
            repeat ($urandom_range(1, 10)) @(negedge aclk);
        end
        s_valid <= 1;
        s_kind <= kind;
        s_sample_ns <= smp;
        s_probability_ppm <= ppm;
        s_clear_after <= clr;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (kind == KIND_REC) record_sample(smp);
        else begin
            stats_q.push_back(query_stats(ppm));
            if (clr) clear_hist();
        end
        @(negedge aclk);
    endtask

    task automatic drain();
        int n;
        n = 0;
        s_valid <= 0;
        while (stats_q.size() != 0 && n < 200000) begin
            @(negedge aclk);
            n++;
        end
        repeat (400) @(negedge aclk);
    endtask

    function automatic logic [63:0] rand_sample();
        int w;
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 4))
            0: return v;
            1: return 64'($urandom_range(0, 20));
            default: begin
                w = $urandom_range(1, 63);
                return v & ((64'd1 << w) - 1);
            end
        endcase
    endfunction

    task automatic test_directed();
        send_word(KIND_QRY, 0, 20'd500000, 0);
        send_word(KIND_REC, 64'd0, 0, 1);
        send_word(KIND_REC, 64'h8000_0000_0000_0000, 0, 0);
        send_word(KIND_REC, ALL64, 0, 0);
        send_word(KIND_REC, 64'h7FFF_FFFF_FFFF_FFFF, 0, 0);
        send_word(KIND_REC, 64'h4000_0000_0000_0000, 0, 0);
        send_word(KIND_REC, 64'd1, 0, 0);
        send_word(KIND_REC, 64'd1000, 0, 0);
        send_word(KIND_QRY, ALL64, 20'd0, 0);
        send_word(KIND_QRY, 0, 20'd1, 0);
        send_word(KIND_QRY, 0, 20'd999000, 0);
        send_word(KIND_QRY, 0, PPM_MAX, 0);
        send_word(KIND_QRY, 0, 20'hFFFFF, 1);
        send_word(KIND_QRY, 0, 20'd900000, 0);
        for (int i = 0; i < 6; i++) send_word(KIND_REC, 64'h7FFF_FFFF_FFFF_FFF0, 0, 0);
        send_word(KIND_QRY, 0, 20'd990000, 0);
        send_word(KIND_QRY, 0, 20'd999900, 1);
        drain();
    endtask

    task automatic test_random();
        logic [19:0] p;
        for (int i = 0; i < 470; i++) begin
            p = ($urandom_range(0, 9) == 0) ? 20'($urandom) : 20'($urandom_range(0, 1000000));
            if ($urandom_range(0, 11) == 0)
                send_word(KIND_QRY, rand_sample(), p, $urandom_range(0, 5) == 0);
            else
                send_word(KIND_REC, rand_sample(), p, 1'($urandom));
        end
        drain();
    endtask

    task automatic test_backpressure();
        hold_rx = 3000;
        for (int i = 0; i < 30; i++)
            send_word(i % 3 == 0 ? KIND_QRY : KIND_REC, rand_sample(), 20'd500000, 0);
        drain();
    endtask

    task automatic test_no_gaps();
        gaps_on = 0;
        for (int i = 0; i < 40; i++)
            send_word(i % 8 == 7 ? KIND_QRY : KIND_REC, rand_sample(),
                      20'($urandom_range(0, 1000000)), i == 39);
        drain();
    endtask

    always @(negedge aclk) begin
        if (hold_rx > 0) begin
            hold_rx <= hold_rx - 1;
            m_ready <= 0;
        end else if (gaps_on) m_ready <= ($urandom_range(0, 3) != 0);
        else m_ready <= 1;
    end

    always @(posedge aclk) begin
        stats_t e;
        if (aresetn && m_valid && m_ready) begin
            if (stats_q.size() == 0) begin
                $display("%0t: result word with none expected", $realtime);
                errors++;
            end else begin
                e = stats_q.pop_front();
                if (m_total_count !== e.cnt) begin
                    $display("%0t: count exp %0d got %0d", $realtime, e.cnt, m_total_count);
                    errors++;
                end
                if (m_min_ns !== e.mn) begin
                    $display("%0t: min exp %0d got %0d", $realtime, e.mn, m_min_ns);
                    errors++;
                end
                if (m_max_ns !== e.mx) begin
                    $display("%0t: max exp %0d got %0d", $realtime, e.mx, m_max_ns);
                    errors++;
                end
                if (m_mean_ns !== e.mean) begin
                    $display("%0t: mean exp %0d got %0d", $realtime, e.mean, m_mean_ns);
                    errors++;
                end
                if (m_percentile_ns !== e.pct) begin
                    $display("%0t: pct exp %0d got %0d", $realtime, e.pct, m_percentile_ns);
                    errors++;
                end
            end
        end
    end

    initial begin
        aresetn = 0;
        s_valid = 0;
        s_kind = 0;
        s_sample_ns = 0;
        s_probability_ppm = 0;
        s_clear_after = 0;
        m_ready = 0;
        clear_hist();
        repeat (9) @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);
        test_directed();
        test_random();
        test_backpressure();
        test_no_gaps();
        if (stats_q.size() != 0) errors++;
        if (errors == 0) $display("All tests passed");
        else $display("Some tests failed");
        $finish;
    end
endmodule
